// File: sv/sparse_transpose_scatter_defines.svh
// ----------------------------------------------------------------------------
// sparse_transpose_scatter_defines
// Assertion macros used by the sparse transpose scatter top level.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TRANSPOSE_SCATTER_DEFINES_SVH
`define SPARSE_TRANSPOSE_SCATTER_DEFINES_SVH

// ante implies cons in the same cycle
`define STS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// expr never holds
`define STS_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// File: sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Types and constants of the sparse transpose scatter block.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int ROW_CNT_W = 11;
  localparam int NNZ_CNT_W = 14;
  localparam int CFG_W     = 14;
  localparam int POS_W     = 14;
  localparam int SLOT_W    = 14;
  localparam int COL_W     = 10;
  localparam int STR_W     = 8;
  localparam int MARK_W    = 16;

  localparam logic [MARK_W-1:0] MARK_MAX = {MARK_W{1'b1}};

  localparam logic REG_ROW_COUNT     = 1'b0;
  localparam logic REG_NONZERO_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_LOAD    = 2'd1,
    ACT_SCATTER = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_STATUS,
    K_LOAD,
    K_SCATTER,
    K_READ,
    K_CLEAR
  } kind_t;

  typedef enum logic [2:0] {
    BS_INIT,
    BS_IDLE,
    BS_SLOT,
    BS_MARK,
    BS_READ,
    BS_CLEAR
  } state_t;

  typedef struct packed {
    kind_t             kind;
    status_t           status;
    logic              rd_entry;
    logic              rd_ptr;
    logic [POS_W-1:0]  position;
    logic [SLOT_W-1:0] pval;
    logic [COL_W-1:0]  srow;
    logic [COL_W-1:0]  scol;
    logic [STR_W-1:0]  strength;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [COL_W-1:0]  entry_column;
    logic [MARK_W-1:0] entry_marker;
    logic [SLOT_W-1:0] insert_pointer;
  } res_t;

  typedef struct packed {
    logic init_busy;
    logic res_push;
    logic cmd_pop;
  } bk_stat_t;

endpackage

// File: sv/sts_fifo.sv
// ----------------------------------------------------------------------------
// sts_fifo
// Two-entry queue, used between front and back and on the result side.
// ----------------------------------------------------------------------------
module sts_fifo #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wdata,
  input  logic         rd_en,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_wr, do_rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: sv/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front
// Input side: takes items and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module sts_front (
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     in_action,
  input  logic [sts_pkg::POS_W-1:0]      in_position,
  input  logic [sts_pkg::SLOT_W-1:0]     in_pointer_value,
  input  logic [sts_pkg::COL_W-1:0]      in_source_row,
  input  logic [sts_pkg::COL_W-1:0]      in_source_column,
  input  logic [sts_pkg::STR_W-1:0]      in_strength,
  input  logic [sts_pkg::ROW_CNT_W-1:0]  n_used,
  input  logic [sts_pkg::NNZ_CNT_W-1:0]  nnz_used,
  input  logic                           init_busy,
  input  logic                           cmdq_full,
  output logic                           cmd_push,
  output sts_pkg::cmd_t                  cmd
);

  logic mat_empty;
  logic pos_le_n;

  assign full      = cmdq_full || init_busy;
  assign cmd_push  = push && !full;
  assign mat_empty = (n_used == '0) || (nnz_used == '0);
  assign pos_le_n  = (in_position <= sts_pkg::POS_W'(n_used));

  always_comb begin
    cmd          = '0;
    cmd.kind     = sts_pkg::K_STATUS;
    cmd.status   = mat_empty ? sts_pkg::ST_EMPTY : sts_pkg::ST_OK;
    cmd.position = in_position;
    cmd.pval     = in_pointer_value;
    cmd.srow     = in_source_row;
    cmd.scol     = in_source_column;
    cmd.strength = in_strength;
    case (sts_pkg::action_t'(in_action))
      sts_pkg::ACT_CLEAR: begin
        cmd.kind = mat_empty ? sts_pkg::K_STATUS : sts_pkg::K_CLEAR;
      end
      sts_pkg::ACT_LOAD: begin
        cmd.kind = (!mat_empty && pos_le_n) ? sts_pkg::K_LOAD : sts_pkg::K_STATUS;
      end
      sts_pkg::ACT_SCATTER: begin
        if (!mat_empty) begin
          if (sts_pkg::ROW_CNT_W'(in_source_column) >= n_used) begin
            cmd.status = sts_pkg::ST_OVERFLOW;
          end else begin
            cmd.kind = sts_pkg::K_SCATTER;
          end
        end
      end
      sts_pkg::ACT_READ: begin
        cmd.kind     = sts_pkg::K_READ;
        cmd.rd_entry = (in_position < nnz_used);
        cmd.rd_ptr   = pos_le_n;
      end
      default: begin
        cmd.kind = sts_pkg::K_STATUS;
      end
    endcase
  end

endmodule

// File: sv/sts_back.sv
// ----------------------------------------------------------------------------
// sts_back
// Execution side: slot, column and marker stores and their sequencer.
// ----------------------------------------------------------------------------
module sts_back #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_NONZEROS = 8192
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  sts_pkg::cmd_t                 cmd_head,
  output logic                          cmd_pop,
  input  logic [sts_pkg::NNZ_CNT_W-1:0] nnz_used,
  input  logic                          res_full,
  output logic                          res_push,
  output sts_pkg::res_t                 res_data,
  output sts_pkg::bk_stat_t             stat
);

  localparam int SLOT_DEPTH = MAX_ROWS + 1;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int ENT_AW     = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam logic [ENT_AW-1:0] ENT_LAST = ENT_AW'(MAX_NONZEROS - 1);

  logic [sts_pkg::SLOT_W-1:0] slot_mem [SLOT_DEPTH];
  logic [sts_pkg::COL_W-1:0]  col_mem  [MAX_NONZEROS];
  logic [sts_pkg::MARK_W-1:0] mark_mem [MAX_NONZEROS];

  sts_pkg::state_t state_r, state_nxt;
  logic [ENT_AW-1:0] cnt_r, cnt_nxt;
  sts_pkg::cmd_t     cmd_r, cmd_nxt;

  logic [sts_pkg::SLOT_W-1:0] slot_rd_r;
  logic [sts_pkg::COL_W-1:0]  col_rd_r;
  logic [sts_pkg::MARK_W-1:0] mark_rd_r;

  logic                       slot_re, slot_we;
  logic [SLOT_AW-1:0]         slot_raddr, slot_waddr;
  logic [sts_pkg::SLOT_W-1:0] slot_wdata;
  logic                       ent_re, ent_we;
  logic [ENT_AW-1:0]          ent_raddr, ent_waddr;
  logic [sts_pkg::COL_W-1:0]  col_wdata;
  logic [sts_pkg::MARK_W-1:0] mark_wdata;
  logic [sts_pkg::MARK_W:0]   sum;
  logic [sts_pkg::MARK_W-1:0] sum_sat;

  assign sum     = {1'b0, mark_rd_r} + (sts_pkg::MARK_W+1)'(cmd_r.strength);
  assign sum_sat = sum[sts_pkg::MARK_W] ? sts_pkg::MARK_MAX : sum[sts_pkg::MARK_W-1:0];

  assign stat.init_busy = (state_r == sts_pkg::BS_INIT);
  assign stat.res_push  = res_push;
  assign stat.cmd_pop   = cmd_pop;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd_nxt    = cmd_r;
    cmd_pop    = 1'b0;
    slot_re    = 1'b0;
    slot_raddr = '0;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    ent_re     = 1'b0;
    ent_raddr  = '0;
    ent_we     = 1'b0;
    ent_waddr  = cnt_r;
    col_wdata  = '0;
    mark_wdata = '0;
    res_push   = 1'b0;
    res_data   = '0;
    case (state_r)
      sts_pkg::BS_INIT, sts_pkg::BS_CLEAR: begin
        ent_we  = 1'b1;
        cnt_nxt = ENT_AW'(cnt_r + 1'b1);
        if (cnt_r == ENT_LAST) begin
          state_nxt = sts_pkg::BS_IDLE;
          if (state_r == sts_pkg::BS_CLEAR) begin
            res_push        = 1'b1;
            res_data.status = cmd_r.status;
          end
        end
      end
      sts_pkg::BS_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_head;
          case (cmd_head.kind)
            sts_pkg::K_LOAD: begin
              slot_we         = 1'b1;
              slot_waddr      = SLOT_AW'(cmd_head.position);
              slot_wdata      = cmd_head.pval;
              res_push        = 1'b1;
              res_data.status = cmd_head.status;
            end
            sts_pkg::K_SCATTER: begin
              slot_re    = 1'b1;
              slot_raddr = SLOT_AW'(cmd_head.scol);
              state_nxt  = sts_pkg::BS_SLOT;
            end
            sts_pkg::K_READ: begin
              slot_re    = cmd_head.rd_ptr;
              slot_raddr = SLOT_AW'(cmd_head.position);
              ent_re     = cmd_head.rd_entry;
              ent_raddr  = ENT_AW'(cmd_head.position);
              state_nxt  = sts_pkg::BS_READ;
            end
            sts_pkg::K_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = sts_pkg::BS_CLEAR;
            end
            default: begin
              res_push        = 1'b1;
              res_data.status = cmd_head.status;
            end
          endcase
        end
      end
      sts_pkg::BS_SLOT: begin
        if (slot_rd_r >= nnz_used) begin
          res_push        = 1'b1;
          res_data.status = sts_pkg::ST_OVERFLOW;
          state_nxt       = sts_pkg::BS_IDLE;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = ENT_AW'(slot_rd_r);
          state_nxt = sts_pkg::BS_MARK;
        end
      end
      sts_pkg::BS_MARK: begin
        ent_we          = 1'b1;
        ent_waddr       = ENT_AW'(slot_rd_r);
        col_wdata       = cmd_r.srow;
        mark_wdata      = sum_sat;
        slot_we         = 1'b1;
        slot_waddr      = SLOT_AW'(cmd_r.scol);
        slot_wdata      = slot_rd_r + 1'b1;
        res_push        = 1'b1;
        res_data.status = cmd_r.status;
        state_nxt       = sts_pkg::BS_IDLE;
      end
      sts_pkg::BS_READ: begin
        res_push                = 1'b1;
        res_data.status         = cmd_r.status;
        res_data.entry_column   = cmd_r.rd_entry ? col_rd_r : '0;
        res_data.entry_marker   = cmd_r.rd_entry ? mark_rd_r : '0;
        res_data.insert_pointer = cmd_r.rd_ptr ? slot_rd_r : '0;
        state_nxt               = sts_pkg::BS_IDLE;
      end
      default: begin
        state_nxt = sts_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sts_pkg::BS_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_r <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      col_mem[ent_waddr]  <= col_wdata;
      mark_mem[ent_waddr] <= mark_wdata;
    end
    if (ent_re) begin
      col_rd_r  <= col_mem[ent_raddr];
      mark_rd_r <= mark_mem[ent_raddr];
    end
  end

endmodule

// File: sv/sparse_transpose_scatter.sv
// ----------------------------------------------------------------------------
// sparse_transpose_scatter
// Builds the transpose of a compressed-row sparse strength matrix.
// ----------------------------------------------------------------------------
//  channel   ports                      transfer when
//  input     push / full, in_*          push && !full
//  result    empty / pop, out_*         pop && !empty
//  config    cfg_wr_en, cfg_index/data  cfg_wr_en
//
//  In the back end, load and no-op items end in idle; read passes the read state;
//  scatter does slot read, marker read and write back (slot read only on slot overflow);
//  clear and reset each zero every entry, and full stays high during the reset pass.
//  A two-entry command queue and a two-entry result queue let input and
//  output stall on their own; the back end waits for result room.
// ----------------------------------------------------------------------------
`include "sparse_transpose_scatter_defines.svh"

module sparse_transpose_scatter #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_NONZEROS = 8192
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_action,
  input  logic [sts_pkg::POS_W-1:0]     in_position,
  input  logic [sts_pkg::SLOT_W-1:0]    in_pointer_value,
  input  logic [sts_pkg::COL_W-1:0]     in_source_row,
  input  logic [sts_pkg::COL_W-1:0]     in_source_column,
  input  logic [sts_pkg::STR_W-1:0]     in_strength,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_status,
  output logic [sts_pkg::COL_W-1:0]     out_entry_column,
  output logic [sts_pkg::MARK_W-1:0]    out_entry_marker,
  output logic [sts_pkg::SLOT_W-1:0]    out_insert_pointer,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [sts_pkg::CFG_W-1:0]     cfg_data
);

  logic [sts_pkg::ROW_CNT_W-1:0] row_count_r, row_count_nxt;
  logic [sts_pkg::NNZ_CNT_W-1:0] nonzero_count_r, nonzero_count_nxt;
  logic [sts_pkg::ROW_CNT_W-1:0] n_used;
  logic [sts_pkg::NNZ_CNT_W-1:0] nnz_used;

  sts_pkg::cmd_t     cmd_in, cmd_head;
  logic              cmd_push, cmdq_full, cmdq_empty;
  sts_pkg::res_t     res_in, res_head;
  logic              res_full;
  logic              cmd_pop, res_push;
  sts_pkg::bk_stat_t bk_stat;

  always_comb begin
    row_count_nxt     = row_count_r;
    nonzero_count_nxt = nonzero_count_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        sts_pkg::REG_ROW_COUNT:     row_count_nxt     = cfg_data[sts_pkg::ROW_CNT_W-1:0];
        sts_pkg::REG_NONZERO_COUNT: nonzero_count_nxt = cfg_data[sts_pkg::NNZ_CNT_W-1:0];
        default: begin
          row_count_nxt = row_count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r     <= '0;
      nonzero_count_r <= '0;
    end else begin
      row_count_r     <= row_count_nxt;
      nonzero_count_r <= nonzero_count_nxt;
    end
  end

  assign n_used   = (int'(row_count_r) < MAX_ROWS) ? row_count_r
                                                   : sts_pkg::ROW_CNT_W'(MAX_ROWS);
  assign nnz_used = (int'(nonzero_count_r) < MAX_NONZEROS) ? nonzero_count_r
                                                           : sts_pkg::NNZ_CNT_W'(MAX_NONZEROS);

  sts_front u_front (
    .push             (push),
    .full             (full),
    .in_action        (in_action),
    .in_position      (in_position),
    .in_pointer_value (in_pointer_value),
    .in_source_row    (in_source_row),
    .in_source_column (in_source_column),
    .in_strength      (in_strength),
    .n_used           (n_used),
    .nnz_used         (nnz_used),
    .init_busy        (bk_stat.init_busy),
    .cmdq_full        (cmdq_full),
    .cmd_push         (cmd_push),
    .cmd              (cmd_in)
  );

  sts_fifo #(
    .W ($bits(sts_pkg::cmd_t))
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cmd_push),
    .wdata (cmd_in),
    .rd_en (cmd_pop),
    .rdata (cmd_head),
    .full  (cmdq_full),
    .empty (cmdq_empty)
  );

  sts_back #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmdq_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .nnz_used  (nnz_used),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in),
    .stat      (bk_stat)
  );

  sts_fifo #(
    .W ($bits(sts_pkg::res_t))
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (res_push),
    .wdata (res_in),
    .rd_en (pop),
    .rdata (res_head),
    .full  (res_full),
    .empty (empty)
  );

  assign out_status         = res_head.status;
  assign out_entry_column   = res_head.entry_column;
  assign out_entry_marker   = res_head.entry_marker;
  assign out_insert_pointer = res_head.insert_pointer;

  `STS_ASSERT_IMP(a_init_blocks_input, bk_stat.init_busy, full, "input open during clearing pass")
  `STS_ASSERT_IMP(a_res_room, bk_stat.res_push, !res_full, "result pushed into full queue")
  `STS_ASSERT_IMP(a_pop_needs_cmd, bk_stat.cmd_pop, !cmdq_empty && !res_full, "command taken without room")
  `STS_ASSERT_IMP(a_overflow_fields, !empty && out_status == sts_pkg::ST_OVERFLOW, out_entry_column == '0 && out_entry_marker == '0 && out_insert_pointer == '0, "overflow result carries data")

endmodule

// File: tb/sv/sts_transpose_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sts_transpose_monitor
// Watches the input, result and register ports of the sparse transpose
// scatter block. Keeps its own copy of the insertion slots, the transposed
// entry stores and the two count registers. Each accepted item yields one
// expected result, and result transfers are checked in order, field by field.
// ----------------------------------------------------------------------------
module sts_transpose_monitor #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_NONZEROS = 8192
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic                       full,
  input  logic [1:0]                 in_action,
  input  logic [sts_pkg::POS_W-1:0]  in_position,
  input  logic [sts_pkg::SLOT_W-1:0] in_pointer_value,
  input  logic [sts_pkg::COL_W-1:0]  in_source_row,
  input  logic [sts_pkg::COL_W-1:0]  in_source_column,
  input  logic [sts_pkg::STR_W-1:0]  in_strength,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [1:0]                 out_status,
  input  logic [sts_pkg::COL_W-1:0]  out_entry_column,
  input  logic [sts_pkg::MARK_W-1:0] out_entry_marker,
  input  logic [sts_pkg::SLOT_W-1:0] out_insert_pointer,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [sts_pkg::CFG_W-1:0]  cfg_data,
  output int                         fail_count,
  output int                         pending_count
);

  logic [sts_pkg::SLOT_W-1:0]    slot_store   [0:MAX_ROWS];
  logic [sts_pkg::COL_W-1:0]     column_store [0:MAX_NONZEROS-1];
  logic [sts_pkg::MARK_W-1:0]    marker_store [0:MAX_NONZEROS-1];
  logic [sts_pkg::ROW_CNT_W-1:0] row_count;
  logic [sts_pkg::NNZ_CNT_W-1:0] nonzero_count;
  sts_pkg::res_t                 awaited_q [$];
  int                            fails;

  initial begin
    fails = 0;
    for (int i = 0; i <= MAX_ROWS; i++) slot_store[i] = '0;
    for (int i = 0; i < MAX_NONZEROS; i++) begin
      column_store[i] = '0;
      marker_store[i] = '0;
    end
  end

  function automatic sts_pkg::res_t apply_action(sts_pkg::action_t act,
                                                 logic [sts_pkg::POS_W-1:0] pos,
                                                 logic [sts_pkg::SLOT_W-1:0] pval,
                                                 logic [sts_pkg::COL_W-1:0] srow,
                                                 logic [sts_pkg::COL_W-1:0] scol,
                                                 logic [sts_pkg::STR_W-1:0] str);
    int unsigned   rows_in_use;
    int unsigned   nz_in_use;
    int unsigned   slot;
    int unsigned   sum;
    bit            vacant;
    sts_pkg::res_t r;
    rows_in_use = (row_count > MAX_ROWS) ? MAX_ROWS : row_count;
    nz_in_use   = (nonzero_count > MAX_NONZEROS) ? MAX_NONZEROS : nonzero_count;
    vacant      = (rows_in_use == 0) || (nz_in_use == 0);
    r           = '0;
    r.status    = vacant ? sts_pkg::ST_EMPTY : sts_pkg::ST_OK;
    case (act)
      sts_pkg::ACT_CLEAR: begin
        if (!vacant) begin
          for (int i = 0; i < MAX_NONZEROS; i++) begin
            column_store[i] = '0;
            marker_store[i] = '0;
          end
        end
      end
      sts_pkg::ACT_LOAD: begin
        if (!vacant && pos <= rows_in_use) slot_store[pos] = pval;
      end
      sts_pkg::ACT_SCATTER: begin
        if (!vacant) begin
          if (scol >= rows_in_use) begin
            r.status = sts_pkg::ST_OVERFLOW;
          end else begin
            slot = slot_store[scol];
            if (slot >= nz_in_use) begin
              r.status = sts_pkg::ST_OVERFLOW;
            end else begin
              sum = marker_store[slot] + str;
              marker_store[slot] = (sum > sts_pkg::MARK_MAX) ? sts_pkg::MARK_MAX
                                                             : sts_pkg::MARK_W'(sum);
              column_store[slot] = srow;
              slot_store[scol]   = sts_pkg::SLOT_W'(slot + 1);
            end
          end
        end
      end
      default: begin
        if (pos < nz_in_use) begin
          r.entry_column = column_store[pos];
          r.entry_marker = marker_store[pos];
        end
        if (pos <= rows_in_use) r.insert_pointer = slot_store[pos];
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    sts_pkg::res_t want;
    if (!rst_n) begin
      row_count     = '0;
      nonzero_count = '0;
      awaited_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == sts_pkg::REG_ROW_COUNT) row_count = cfg_data[sts_pkg::ROW_CNT_W-1:0];
        else nonzero_count = cfg_data[sts_pkg::NNZ_CNT_W-1:0];
      end
      // result side first: a result never belongs to an item taken at the same edge
      if (pop && !empty) begin
        if (awaited_q.size() == 0) begin
          fails++;
          $error("result transfer with nothing expected: status %0d", out_status);
        end else begin
          want = awaited_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("entry_column", want.entry_column, out_entry_column);
          check_field("entry_marker", want.entry_marker, out_entry_marker);
          check_field("insert_pointer", want.insert_pointer, out_insert_pointer);
        end
      end
      if (push && !full) begin
        awaited_q.push_back(apply_action(sts_pkg::action_t'(in_action), in_position,
                                         in_pointer_value, in_source_row,
                                         in_source_column, in_strength));
      end
    end
    fail_count    <= fails;
    pending_count <= awaited_q.size();
  end

endmodule

// File: tb/sv/tb_sparse_transpose_scatter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_transpose_scatter
// Drives the sparse transpose scatter block through empty-matrix, pointer
// load, scatter, read and clear traffic over a series of row and nonzero
// counts, including a long run that saturates one entry marker. Both sides
// idle in random bursts; the monitor checks every result transfer.
// ----------------------------------------------------------------------------
module tb_sparse_transpose_scatter;

  localparam int MAX_ROWS      = 1024;
  localparam int MAX_NONZEROS  = 8192;
  localparam int RANDOM_CLEARS = 8;
  localparam int PHASE_ITEMS   = 115;

  logic                       clk                = 1'b0;
  logic                       rst_n              = 1'b0;
  logic                       push               = 1'b0;
  logic                       full;
  logic [1:0]                 in_action          = sts_pkg::ACT_CLEAR;
  logic [sts_pkg::POS_W-1:0]  in_position        = '0;
  logic [sts_pkg::SLOT_W-1:0] in_pointer_value   = '0;
  logic [sts_pkg::COL_W-1:0]  in_source_row      = '0;
  logic [sts_pkg::COL_W-1:0]  in_source_column   = '0;
  logic [sts_pkg::STR_W-1:0]  in_strength        = '0;
  logic                       empty;
  logic                       pop                = 1'b0;
  logic [1:0]                 out_status;
  logic [sts_pkg::COL_W-1:0]  out_entry_column;
  logic [sts_pkg::MARK_W-1:0] out_entry_marker;
  logic [sts_pkg::SLOT_W-1:0] out_insert_pointer;
  logic                       cfg_wr_en          = 1'b0;
  logic                       cfg_index          = sts_pkg::REG_ROW_COUNT;
  logic [sts_pkg::CFG_W-1:0]  cfg_data           = '0;
  int                         fail_count;
  int                         pending_count;

  bit calm        = 1'b0;
  bit last_clear  = 1'b0;
  int rows_used   = 0;
  int nonzeros_used = 0;
  int clears_left = RANDOM_CLEARS;
  bit written_slot [0:MAX_ROWS];
  int loaded_columns [$];
  int recent_slots [$];

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  sparse_transpose_scatter u_dut (.*);

  sts_transpose_monitor u_monitor (.*);

  function automatic bit matrix_empty();
    return (rows_used == 0) || (nonzeros_used == 0);
  endfunction

  task automatic set_config(int rows, int nonzeros);
    cfg_wr_en <= 1'b1;
    cfg_index <= sts_pkg::REG_ROW_COUNT;
    cfg_data  <= sts_pkg::CFG_W'(rows);
    @(negedge clk);
    cfg_index <= sts_pkg::REG_NONZERO_COUNT;
    cfg_data  <= sts_pkg::CFG_W'(nonzeros);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rows_used     = (rows > MAX_ROWS) ? MAX_ROWS : rows;
    nonzeros_used = (nonzeros > MAX_NONZEROS) ? MAX_NONZEROS : nonzeros;
  endtask

  // called and returns at a falling edge
  task automatic send(sts_pkg::action_t act, int pos, int pval, int srow, int scol, int str);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    push             <= 1'b1;
    in_action        <= act;
    in_position      <= sts_pkg::POS_W'(pos);
    in_pointer_value <= sts_pkg::SLOT_W'(pval);
    in_source_row    <= sts_pkg::COL_W'(srow);
    in_source_column <= sts_pkg::COL_W'(scol);
    in_strength      <= sts_pkg::STR_W'(str);
    do @(posedge clk); while (full);
    @(negedge clk);
    last_clear = (act == sts_pkg::ACT_CLEAR);
    if (act == sts_pkg::ACT_LOAD && !matrix_empty() && pos <= rows_used) begin
      written_slot[pos] = 1'b1;
      if (pos < MAX_ROWS) loaded_columns.push_back(pos);
      if (pval < nonzeros_used) begin
        recent_slots.push_back(pval);
        if (recent_slots.size() > 32) void'(recent_slots.pop_front());
      end
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (last_clear ? MAX_NONZEROS + 16 : 16) @(negedge clk);
  endtask

  function automatic int pick_pointer();
    int roll;
    roll = $urandom_range(0, 9);
    if (nonzeros_used > 0 && roll < 7) return $urandom_range(0, nonzeros_used - 1);
    if (roll < 8) return nonzeros_used;
    return $urandom_range(0, 16383);
  endfunction

  function automatic int pick_load_position();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) return $urandom_range(0, rows_used);
    if (roll < 9) return rows_used + 1;
    return $urandom_range(0, 16383);
  endfunction

  // never scatter through a slot that was not loaded
  function automatic int pick_column();
    int c;
    if (loaded_columns.size() > 0 && $urandom_range(0, 9) < 8)
      return loaded_columns[$urandom_range(0, loaded_columns.size() - 1)];
    c = $urandom_range(0, 1023);
    if (!matrix_empty() && c < rows_used && !written_slot[c])
      c = (rows_used < MAX_ROWS) ? $urandom_range(rows_used, 1023) : loaded_columns[0];
    return c;
  endfunction

  function automatic int pick_read_position();
    int roll;
    int p;
    roll = $urandom_range(0, 9);
    if (roll < 5 && recent_slots.size() > 0)
      p = recent_slots[$urandom_range(0, recent_slots.size() - 1)] + $urandom_range(0, 3);
    else if (roll < 7 && loaded_columns.size() > 0)
      p = loaded_columns[$urandom_range(0, loaded_columns.size() - 1)];
    else if (roll < 8)
      p = $urandom_range(0, nonzeros_used);
    else
      p = $urandom_range(0, 16383);
    if (p > 16383) p = 16383;
    if (p <= rows_used && !written_slot[p])
      p = (loaded_columns.size() > 0) ?
          loaded_columns[$urandom_range(0, loaded_columns.size() - 1)] : rows_used + 1;
    return p;
  endfunction

  task automatic run_phase(int rows, int nonzeros, int items, bit quiet);
    int sent;
    int lim;
    int stride;
    int col;
    int reps;
    int roll;
    wait_idle();
    set_config(rows, nonzeros);
    calm   = quiet;
    sent   = 0;
    lim    = (rows_used < 40) ? rows_used : 40;
    stride = nonzeros_used / (lim + 1);
    // row pointer table for the first rows, as a real matrix load would give
    if (!matrix_empty()) begin
      for (int i = 0; i <= lim; i++) begin
        send(sts_pkg::ACT_LOAD, i, i * stride, $urandom_range(0, 1023),
             $urandom_range(0, 1023), $urandom_range(0, 255));
        sent++;
      end
    end
    while (sent < items) begin
      roll = $urandom_range(0, 99);
      if (roll == 0 && clears_left > 0) begin
        clears_left--;
        send(sts_pkg::ACT_CLEAR, $urandom_range(0, 16383), $urandom_range(0, 16383),
             $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 255));
        sent++;
      end else if (roll < 25) begin
        send(sts_pkg::ACT_LOAD, pick_load_position(), pick_pointer(),
             $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 255));
        sent++;
      end else if (roll < 65) begin
        col  = pick_column();
        reps = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
        repeat (reps) begin
          send(sts_pkg::ACT_SCATTER, $urandom_range(0, 16383), $urandom_range(0, 16383),
               $urandom_range(0, 1023), col, $urandom_range(0, 255));
          sent++;
        end
      end else begin
        send(sts_pkg::ACT_READ, pick_read_position(), $urandom_range(0, 16383),
             $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 255));
        sent++;
      end
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // counts still zero after reset: every action reports an empty matrix
    send(sts_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
    send(sts_pkg::ACT_LOAD, 3, 7, 0, 0, 0);
    send(sts_pkg::ACT_SCATTER, 0, 0, 12, 2, 200);
    send(sts_pkg::ACT_READ, 20, 0, 0, 0, 0);

    wait_idle();
    set_config(8, 32);
    for (int i = 0; i <= 8; i++) send(sts_pkg::ACT_LOAD, i, (i == 7) ? 31 : 4 * i, 0, 0, 0);
    send(sts_pkg::ACT_LOAD, 9, 5, 0, 0, 0);
    send(sts_pkg::ACT_LOAD, 16383, 16383, 1023, 1023, 255);
    send(sts_pkg::ACT_SCATTER, 0, 0, 1023, 0, 255);
    send(sts_pkg::ACT_SCATTER, 0, 0, 0, 0, 255);
    send(sts_pkg::ACT_SCATTER, 0, 0, 5, 7, 0);
    send(sts_pkg::ACT_SCATTER, 0, 0, 6, 7, 1);        // slot reaches the nonzero count
    send(sts_pkg::ACT_SCATTER, 0, 0, 1, 8, 9);        // column past the row count
    send(sts_pkg::ACT_SCATTER, 16383, 16383, 1023, 1023, 255);
    send(sts_pkg::ACT_READ, 0, 0, 0, 0, 0);
    send(sts_pkg::ACT_READ, 31, 0, 0, 0, 0);
    send(sts_pkg::ACT_READ, 8, 0, 0, 0, 0);
    send(sts_pkg::ACT_READ, 16383, 16383, 1023, 1023, 255);
    send(sts_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
    send(sts_pkg::ACT_READ, 0, 0, 0, 0, 0);

    // pile strength onto one entry until the marker saturates
    wait_idle();
    set_config(32, 256);
    repeat (300) begin
      send(sts_pkg::ACT_LOAD, 5, 100, $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 255));
      send(sts_pkg::ACT_SCATTER, $urandom_range(0, 16383), $urandom_range(0, 16383),
           $urandom_range(0, 1023), 5, $urandom_range(220, 255));
    end
    send(sts_pkg::ACT_READ, 100, 0, 0, 0, 0);
    send(sts_pkg::ACT_READ, 5, 0, 0, 0, 0);

    run_phase(1024, 8192, PHASE_ITEMS, 1'b0);
    run_phase(2047, 16383, PHASE_ITEMS, 1'b0);
    run_phase(16, 64, PHASE_ITEMS, 1'b1);
    run_phase(1, 1, PHASE_ITEMS, 1'b0);
    run_phase(0, 500, PHASE_ITEMS, 1'b0);
    run_phase(40, 0, PHASE_ITEMS, 1'b0);
    run_phase($urandom_range(2, 100), $urandom_range(50, 400), PHASE_ITEMS, 1'b0);
    run_phase(1024, 300, PHASE_ITEMS, 1'b0);
    run_phase(30, 8192, PHASE_ITEMS, 1'b1);

    wait_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/sts_pkg.sv
sv/sts_fifo.sv
sv/sts_front.sv
sv/sts_back.sv
sv/sparse_transpose_scatter.sv
tb/sv/sts_transpose_monitor.sv
tb/sv/tb_sparse_transpose_scatter.sv
